/* src/bezier_path_flattener_core_defines.svh */
// Assertion macros for the path flattener core.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef BEZIER_PATH_FLATTENER_CORE_DEFINES_SVH
`define BEZIER_PATH_FLATTENER_CORE_DEFINES_SVH

// Same-cycle implication.
`define BPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bpf_pkg.sv */
// Shared types and constants of the path flattener.
// No dependencies.
`default_nettype none
package bpf_pkg;

  localparam int COORD_W = 32;
  localparam int T_BITS = 17;
  localparam logic [T_BITS-1:0] T_ONE = 17'h10000;
  localparam int MIN_SEGMENTS = 8;
  localparam int DIV_CNT_W = $clog2(T_BITS + 1);

  localparam logic [2:0] KIND_MOVE  = 3'd0;
  localparam logic [2:0] KIND_LINE  = 3'd1;
  localparam logic [2:0] KIND_CLOSE = 3'd2;
  localparam logic [2:0] KIND_CUBIC = 3'd3;
  localparam logic [2:0] KIND_QUAD  = 3'd4;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SPAN = 6'b000010,
    ST_SEGS = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_EVAL = 6'b010000,
    ST_PUT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

/* src/bpf_lerp.sv */
// Shared interpolation unit: a + round((b - a) * t), t in Q1.16.
// Depends on bpf_pkg.
`default_nettype none
module bpf_lerp (
  input  var bpf_pkg::coord_t          a_i,
  input  var bpf_pkg::coord_t          b_i,
  input  logic [bpf_pkg::T_BITS-1:0]   t_i,
  output bpf_pkg::coord_t              y_o
);

  logic signed [32:0] diff;
  logic signed [50:0] prod;
  logic signed [50:0] rnd;

  assign diff = {b_i[31], b_i} - {a_i[31], a_i};
  assign prod = diff * $signed({1'b0, t_i});
  assign rnd  = prod + 51'sd32768;
  assign y_o  = a_i + $signed(rnd[47:16]);

endmodule
`default_nettype wire

/* src/bpf_div.sv */
// Restoring divider: 65536 / divisor, one quotient bit per cycle.
// Depends on bpf_pkg.
`default_nettype none
module bpf_div #(
  parameter int SEG_W = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic [SEG_W-1:0]              divisor_i,
  output bpf_pkg::div_stat_t            stat_o,
  output logic [bpf_pkg::T_BITS-1:0]    quot_o,
  output logic [SEG_W-1:0]              rem_o
);

  logic [bpf_pkg::T_BITS-1:0]    num_r, num_nxt;
  logic [SEG_W-1:0]              rem_r, rem_nxt;
  logic [SEG_W-1:0]              dvs_r, dvs_nxt;
  logic [bpf_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [SEG_W:0]                tr;
  logic [SEG_W:0]                sub;
  logic                          ge;

  assign tr  = {rem_r, num_r[bpf_pkg::T_BITS-1]};
  assign ge  = tr >= {1'b0, dvs_r};
  assign sub = tr - {1'b0, dvs_r};

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start_i) begin
      num_nxt  = bpf_pkg::T_ONE;
      rem_nxt  = '0;
      dvs_nxt  = divisor_i;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[bpf_pkg::T_BITS-2:0], ge};
      rem_nxt = ge ? sub[SEG_W-1:0] : tr[SEG_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == bpf_pkg::DIV_CNT_W'(bpf_pkg::T_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat_o.busy = busy_r;
  assign stat_o.done = done_r;
  assign quot_o      = num_r;
  assign rem_o       = rem_r;

endmodule
`default_nettype wire

/* src/bezier_path_flattener_core.sv */
// Path flattener top level: command sequencer, curve evaluator, output register.
// Depends on bpf_pkg, bpf_lerp, bpf_div and bezier_path_flattener_core_defines.svh.
//
//   channel | direction | ports
//   in      | input     | in_valid, in_stall, in_kind, in_p1_x .. in_p3_y
//   out     | output    | out_valid, out_stall, out_point_x, out_point_y, out_last
//
// A curve finds its segment count (ST_SPAN, ST_SEGS), runs the divider
// (ST_DIV), then per point evaluates on the shared interpolation unit (ST_EVAL)
// and transfers the point (ST_PUT). Rst_n clears the current and start points.
// A stalled output holds the sequencer and blocks input.
`default_nettype none
`include "bezier_path_flattener_core_defines.svh"
module bezier_path_flattener_core #(
  parameter int MAX_SEGMENTS = 64,
  parameter int FRAC_BITS    = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             in_kind,
  input  logic signed [31:0]     in_p1_x,
  input  logic signed [31:0]     in_p1_y,
  input  logic signed [31:0]     in_p2_x,
  input  logic signed [31:0]     in_p2_y,
  input  logic signed [31:0]     in_p3_x,
  input  logic signed [31:0]     in_p3_y,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     out_point_x,
  output logic signed [31:0]     out_point_y,
  output logic                   out_last
);

  localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
  localparam int SH    = 3 + FRAC_BITS;

  bpf_pkg::state_t state_r, state_nxt;
  bpf_pkg::coord_t cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  bpf_pkg::coord_t st_x_r, st_x_nxt, st_y_r, st_y_nxt;
  bpf_pkg::coord_t p0x_r, p0x_nxt, p0y_r, p0y_nxt, p1x_r, p1x_nxt, p1y_r, p1y_nxt;
  bpf_pkg::coord_t p2x_r, p2x_nxt, p2y_r, p2y_nxt, p3x_r, p3x_nxt, p3y_r, p3y_nxt;
  bpf_pkg::coord_t q0x_r, q0x_nxt, q0y_r, q0y_nxt, q1x_r, q1x_nxt, q1y_r, q1y_nxt;
  bpf_pkg::coord_t q2x_r, q2x_nxt, q2y_r, q2y_nxt, r0x_r, r0x_nxt, r0y_r, r0y_nxt;
  bpf_pkg::coord_t r1x_r, r1x_nxt, r1y_r, r1y_nxt, ox_r, ox_nxt, oy_r, oy_nxt;
  bpf_pkg::coord_t opx_r, opx_nxt, opy_r, opy_nxt;
  logic            olast_r, olast_nxt, ovalid_r, ovalid_nxt;
  logic            cubic_r, cubic_nxt;
  logic [32:0]     sx_r, sx_nxt, sy_r, sy_nxt;
  logic [SEG_W-1:0] segs_r, segs_nxt, idx_r, idx_nxt, acc_r, acc_nxt;
  logic [bpf_pkg::T_BITS-1:0] t_r, t_nxt;
  logic [3:0]      step_r, step_nxt;

  logic            out_free, accept, div_start;
  bpf_pkg::coord_t la, lb, ly;
  bpf_pkg::coord_t mnx, mxx, mny, mxy;
  logic [32:0]     span;
  logic [33:0]     ncnt;
  logic [SEG_W-1:0] segs_cl;
  bpf_pkg::div_stat_t div_stat;
  logic [bpf_pkg::T_BITS-1:0] div_quot, t_adv;
  logic [SEG_W-1:0] div_rem;
  logic [SEG_W:0]  adv_sum;
  logic            adv_ge;
  logic [SEG_W-1:0] acc_adv;

  assign out_free = !ovalid_r || !out_stall;
  assign in_stall = !((state_r == bpf_pkg::ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  bpf_lerp u_lerp (.a_i(la), .b_i(lb), .t_i(t_r), .y_o(ly));

  bpf_div #(.SEG_W(SEG_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start_i(div_start), .divisor_i(segs_cl),
    .stat_o(div_stat), .quot_o(div_quot), .rem_o(div_rem)
  );

  assign div_start = (state_r == bpf_pkg::ST_SEGS);

  // control box extents
  always_comb begin
    mnx = p0x_r; mxx = p0x_r; mny = p0y_r; mxy = p0y_r;
    if (p1x_r < mnx) mnx = p1x_r;
    if (p2x_r < mnx) mnx = p2x_r;
    if (p3x_r < mnx) mnx = p3x_r;
    if (p1x_r > mxx) mxx = p1x_r;
    if (p2x_r > mxx) mxx = p2x_r;
    if (p3x_r > mxx) mxx = p3x_r;
    if (p1y_r < mny) mny = p1y_r;
    if (p2y_r < mny) mny = p2y_r;
    if (p3y_r < mny) mny = p3y_r;
    if (p1y_r > mxy) mxy = p1y_r;
    if (p2y_r > mxy) mxy = p2y_r;
    if (p3y_r > mxy) mxy = p3y_r;
  end

  assign span = (sx_r > sy_r) ? sx_r : sy_r;
  assign ncnt = ({1'b0, span} + 34'((34'd1 << SH) - 34'd1)) >> SH;

  always_comb begin
    priority if (ncnt < 34'(bpf_pkg::MIN_SEGMENTS)) begin
      segs_cl = SEG_W'(bpf_pkg::MIN_SEGMENTS);
    end else if (ncnt > 34'(MAX_SEGMENTS)) begin
      segs_cl = SEG_W'(MAX_SEGMENTS);
    end else begin
      segs_cl = ncnt[SEG_W-1:0];
    end
  end

  // running t = i * 65536 / segs
  assign adv_sum = {1'b0, acc_r} + {1'b0, div_rem};
  assign adv_ge  = adv_sum >= {1'b0, segs_r};
  assign acc_adv = adv_ge ? SEG_W'(adv_sum - {1'b0, segs_r}) : adv_sum[SEG_W-1:0];
  assign t_adv   = t_r + div_quot + bpf_pkg::T_BITS'(adv_ge);

  // interpolation operands
  always_comb begin
    unique case (step_r)
      4'd0:    begin la = p0x_r; lb = p1x_r; end
      4'd1:    begin la = p0y_r; lb = p1y_r; end
      4'd2:    begin la = p1x_r; lb = p2x_r; end
      4'd3:    begin la = p1y_r; lb = p2y_r; end
      4'd4:    begin la = p2x_r; lb = p3x_r; end
      4'd5:    begin la = p2y_r; lb = p3y_r; end
      4'd6:    begin la = q0x_r; lb = q1x_r; end
      4'd7:    begin la = q0y_r; lb = q1y_r; end
      4'd8:    begin la = q1x_r; lb = q2x_r; end
      4'd9:    begin la = q1y_r; lb = q2y_r; end
      4'd10:   begin la = cubic_r ? r0x_r : q0x_r; lb = cubic_r ? r1x_r : q1x_r; end
      4'd11:   begin la = cubic_r ? r0y_r : q0y_r; lb = cubic_r ? r1y_r : q1y_r; end
      default: begin la = p0x_r; lb = p0x_r; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cur_x_nxt = cur_x_r; cur_y_nxt = cur_y_r; st_x_nxt = st_x_r; st_y_nxt = st_y_r;
    p0x_nxt = p0x_r; p0y_nxt = p0y_r; p1x_nxt = p1x_r; p1y_nxt = p1y_r;
    p2x_nxt = p2x_r; p2y_nxt = p2y_r; p3x_nxt = p3x_r; p3y_nxt = p3y_r;
    q0x_nxt = q0x_r; q0y_nxt = q0y_r; q1x_nxt = q1x_r; q1y_nxt = q1y_r;
    q2x_nxt = q2x_r; q2y_nxt = q2y_r; r0x_nxt = r0x_r; r0y_nxt = r0y_r;
    r1x_nxt = r1x_r; r1y_nxt = r1y_r; ox_nxt = ox_r; oy_nxt = oy_r;
    opx_nxt = opx_r; opy_nxt = opy_r; olast_nxt = olast_r;
    ovalid_nxt = ovalid_r && out_stall;
    cubic_nxt = cubic_r; sx_nxt = sx_r; sy_nxt = sy_r; segs_nxt = segs_r;
    idx_nxt = idx_r; acc_nxt = acc_r; t_nxt = t_r; step_nxt = step_r;
    unique case (state_r)
      bpf_pkg::ST_IDLE: begin
        if (accept) begin
          p0x_nxt = cur_x_r; p0y_nxt = cur_y_r;
          p1x_nxt = in_p1_x; p1y_nxt = in_p1_y;
          p2x_nxt = in_p2_x; p2y_nxt = in_p2_y;
          priority case (in_kind)
            bpf_pkg::KIND_MOVE, bpf_pkg::KIND_LINE: begin
              cur_x_nxt = in_p1_x; cur_y_nxt = in_p1_y;
              if (in_kind == bpf_pkg::KIND_MOVE) begin
                st_x_nxt = in_p1_x; st_y_nxt = in_p1_y;
              end
              opx_nxt = in_p1_x; opy_nxt = in_p1_y; olast_nxt = 1'b1; ovalid_nxt = 1'b1;
            end
            bpf_pkg::KIND_CLOSE: begin
              cur_x_nxt = st_x_r; cur_y_nxt = st_y_r;
            end
            bpf_pkg::KIND_CUBIC: begin
              p3x_nxt = in_p3_x; p3y_nxt = in_p3_y; cubic_nxt = 1'b1;
              cur_x_nxt = in_p3_x; cur_y_nxt = in_p3_y;
              state_nxt = bpf_pkg::ST_SPAN;
            end
            bpf_pkg::KIND_QUAD: begin
              p3x_nxt = in_p2_x; p3y_nxt = in_p2_y; cubic_nxt = 1'b0;
              cur_x_nxt = in_p2_x; cur_y_nxt = in_p2_y;
              state_nxt = bpf_pkg::ST_SPAN;
            end
            default: begin
            end
          endcase
        end
      end
      bpf_pkg::ST_SPAN: begin
        sx_nxt = 33'({mxx[31], mxx} - {mnx[31], mnx});
        sy_nxt = 33'({mxy[31], mxy} - {mny[31], mny});
        state_nxt = bpf_pkg::ST_SEGS;
      end
      bpf_pkg::ST_SEGS: begin
        segs_nxt = segs_cl;
        acc_nxt = '0;
        t_nxt = '0;
        state_nxt = bpf_pkg::ST_DIV;
      end
      bpf_pkg::ST_DIV: begin
        if (div_stat.done) begin
          t_nxt = t_adv; acc_nxt = acc_adv;
          idx_nxt = SEG_W'(1);
          step_nxt = '0;
          state_nxt = bpf_pkg::ST_EVAL;
        end
      end
      bpf_pkg::ST_EVAL: begin
        step_nxt = step_r + 4'd1;
        unique case (step_r)
          4'd0:  q0x_nxt = ly;
          4'd1:  q0y_nxt = ly;
          4'd2:  q1x_nxt = ly;
          4'd3:  begin q1y_nxt = ly; if (!cubic_r) step_nxt = 4'd10; end
          4'd4:  q2x_nxt = ly;
          4'd5:  q2y_nxt = ly;
          4'd6:  r0x_nxt = ly;
          4'd7:  r0y_nxt = ly;
          4'd8:  r1x_nxt = ly;
          4'd9:  r1y_nxt = ly;
          4'd10: ox_nxt = ly;
          4'd11: begin oy_nxt = ly; state_nxt = bpf_pkg::ST_PUT; end
          default: state_nxt = bpf_pkg::ST_PUT;
        endcase
      end
      bpf_pkg::ST_PUT: begin
        if (out_free) begin
          opx_nxt = ox_r; opy_nxt = oy_r; ovalid_nxt = 1'b1;
          olast_nxt = (idx_r == segs_r);
          if (idx_r == segs_r) begin
            state_nxt = bpf_pkg::ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
            t_nxt = t_adv; acc_nxt = acc_adv;
            step_nxt = '0;
            state_nxt = bpf_pkg::ST_EVAL;
          end
        end
      end
      default: state_nxt = bpf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bpf_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
      cur_x_r  <= '0; cur_y_r <= '0; st_x_r <= '0; st_y_r <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      cur_x_r  <= cur_x_nxt; cur_y_r <= cur_y_nxt;
      st_x_r   <= st_x_nxt; st_y_r <= st_y_nxt;
    end
    p0x_r <= p0x_nxt; p0y_r <= p0y_nxt; p1x_r <= p1x_nxt; p1y_r <= p1y_nxt;
    p2x_r <= p2x_nxt; p2y_r <= p2y_nxt; p3x_r <= p3x_nxt; p3y_r <= p3y_nxt;
    q0x_r <= q0x_nxt; q0y_r <= q0y_nxt; q1x_r <= q1x_nxt; q1y_r <= q1y_nxt;
    q2x_r <= q2x_nxt; q2y_r <= q2y_nxt; r0x_r <= r0x_nxt; r0y_r <= r0y_nxt;
    r1x_r <= r1x_nxt; r1y_r <= r1y_nxt; ox_r <= ox_nxt; oy_r <= oy_nxt;
    opx_r <= opx_nxt; opy_r <= opy_nxt; olast_r <= olast_nxt;
    cubic_r <= cubic_nxt; sx_r <= sx_nxt; sy_r <= sy_nxt; segs_r <= segs_nxt;
    idx_r <= idx_nxt; acc_r <= acc_nxt; t_r <= t_nxt; step_r <= step_nxt;
  end

  assign out_valid   = ovalid_r;
  assign out_point_x = opx_r;
  assign out_point_y = opy_r;
  assign out_last    = olast_r;

  `BPF_ASSERT_IMP(a_segs_range, state_r == bpf_pkg::ST_EVAL,
    segs_r >= SEG_W'(bpf_pkg::MIN_SEGMENTS) && segs_r <= SEG_W'(MAX_SEGMENTS),
    "segment count out of range")
  `BPF_ASSERT_IMP(a_idx_bound, state_r == bpf_pkg::ST_EVAL || state_r == bpf_pkg::ST_PUT,
    idx_r != '0 && idx_r <= segs_r, "point index out of range")
  `BPF_ASSERT_IMP(a_last_t_one, state_r == bpf_pkg::ST_PUT && idx_r == segs_r,
    t_r == bpf_pkg::T_ONE, "final curve point not at t = 1")
  `BPF_ASSERT_NXT(a_div_done, state_r == bpf_pkg::ST_SEGS, div_stat.busy,
    "divider did not start")

endmodule
`default_nettype wire
